// File: design/gvbi_pkg.sv
`timescale 1ns / 1ps

package gvbi_pkg;

  localparam int GRID_R_POINTS = 64;
  localparam int GRID_Z_POINTS = 64;

  // grid split four ways by column and row parity so one query reads every bank once
  localparam int NUM_BANKS  = 4;
  localparam int R_HALF     = (GRID_R_POINTS + 1) / 2;
  localparam int Z_HALF     = (GRID_Z_POINTS + 1) / 2;
  localparam int BANK_DEPTH = R_HALF * Z_HALF;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int RW         = $clog2(GRID_R_POINTS);
  localparam int ZW         = $clog2(GRID_Z_POINTS);

  localparam int IDX_W  = 6;
  localparam int COMP_W = 32;

  typedef logic [COMP_W-1:0] q16_t;

  // r in the low bits
  typedef struct packed {
    q16_t phi;
    q16_t z;
    q16_t r;
  } vec_t;

  typedef logic [BANK_AW-1:0] baddr_t;
  typedef logic [32:0]        weight_t;

  typedef enum logic [1:0] {
    CFG_R_ORIGIN = 2'd0,
    CFG_Z_ORIGIN = 2'd1,
    CFG_R_RECIP  = 2'd2,
    CFG_Z_RECIP  = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } stage_en_t;

  typedef struct packed {
    logic       query;
    logic       wr_ok;
    logic [1:0] wr_bank;
  } loc_ctl_t;

  function automatic baddr_t bank_addr(input logic [31:0] col, input logic [31:0] row);
    logic [31:0] a;
    a = (row >> 1) * 32'(R_HALF) + (col >> 1);
    return a[BANK_AW-1:0];
  endfunction

endpackage

// File: design/gvbi_bank_ram.sv
`timescale 1ns / 1ps

module gvbi_bank_ram import gvbi_pkg::*; (
  input  logic   clk,
  input  logic   we,
  input  baddr_t waddr,
  input  vec_t   wdata,
  input  logic   re,
  input  baddr_t raddr,
  output vec_t   rdata
);

  vec_t mem [BANK_DEPTH];
  vec_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/gvbi_locate.sv
`timescale 1ns / 1ps

module gvbi_locate import gvbi_pkg::*; (
  input  logic                          clk,
  input  stage_en_t                     en,
  input  logic                          in_query,
  input  logic [IDX_W-1:0]              in_wr_r_index,
  input  logic [IDX_W-1:0]              in_wr_z_index,
  input  vec_t                          in_wr_vec,
  input  q16_t                          in_point_r,
  input  q16_t                          in_point_z,
  input  q16_t                          r_origin,
  input  q16_t                          z_origin,
  input  logic [31:0]                   r_step_recip,
  input  logic [31:0]                   z_step_recip,
  output loc_ctl_t                      ctl,
  output baddr_t                        wr_addr,
  output vec_t                          wr_vec,
  output baddr_t [NUM_BANKS-1:0]        rd_addr,
  output weight_t [NUM_BANKS-1:0]       weights,
  output logic                          in_range,
  output logic                          ir_odd,
  output logic                          iz_odd
);

  // stage 1: origin offsets
  logic              query1_r;
  logic [IDX_W-1:0]  wc1_r;
  logic [IDX_W-1:0]  wz1_r;
  vec_t              vec1_r;
  logic signed [32:0] off_r1_r;
  logic signed [32:0] off_z1_r;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      query1_r <= in_query;
      wc1_r    <= in_wr_r_index;
      wz1_r    <= in_wr_z_index;
      vec1_r   <= in_wr_vec;
      off_r1_r <= $signed({in_point_r[31], in_point_r}) - $signed({r_origin[31], r_origin});
      off_z1_r <= $signed({in_point_z[31], in_point_z}) - $signed({z_origin[31], z_origin});
    end
  end

  // stage 2: scaled grid coordinates, Q32.32
  logic        query2_r;
  logic        wr_ok2_r;
  logic [1:0]  wr_bank2_r;
  baddr_t      wr_addr2_r;
  vec_t        vec2_r;
  logic [63:0] sr_r;
  logic [63:0] sz_r;
  logic        bad_r_r;
  logic        bad_z_r;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      query2_r   <= query1_r;
      wr_ok2_r   <= (32'(wc1_r) < 32'(GRID_R_POINTS)) && (32'(wz1_r) < 32'(GRID_Z_POINTS));
      wr_bank2_r <= {wz1_r[0], wc1_r[0]};
      wr_addr2_r <= bank_addr(32'(wc1_r), 32'(wz1_r));
      vec2_r     <= vec1_r;
      // below the origin: out of range unless the reciprocal is zero
      sr_r       <= off_r1_r[32] ? 64'd0 : ({32'd0, off_r1_r[31:0]} * {32'd0, r_step_recip});
      sz_r       <= off_z1_r[32] ? 64'd0 : ({32'd0, off_z1_r[31:0]} * {32'd0, z_step_recip});
      bad_r_r    <= off_r1_r[32] && (r_step_recip != 32'd0);
      bad_z_r    <= off_z1_r[32] && (z_step_recip != 32'd0);
    end
  end

  // cell indices, fractions and corner weights
  logic [RW-1:0] ir;
  logic [ZW-1:0] iz;
  logic [RW-1:0] ir1;
  logic [ZW-1:0] iz1;
  logic [15:0]   fr;
  logic [15:0]   fz;
  logic [16:0]   fr_c;
  logic [16:0]   fz_c;
  logic          ok_r;
  logic          ok_z;

  assign ir   = sr_r[32 +: RW];
  assign iz   = sz_r[32 +: ZW];
  assign ir1  = ir + RW'(1);
  assign iz1  = iz + ZW'(1);
  assign fr   = sr_r[31:16];
  assign fz   = sz_r[31:16];
  assign fr_c = 17'h10000 - {1'b0, fr};
  assign fz_c = 17'h10000 - {1'b0, fz};
  assign ok_r = !bad_r_r && (sr_r[63:32] <= 32'(GRID_R_POINTS - 2));
  assign ok_z = !bad_z_r && (sz_r[63:32] <= 32'(GRID_Z_POINTS - 2));

  assign weights[0] = weight_t'({17'd0, fr_c} * {17'd0, fz_c});
  assign weights[1] = weight_t'({17'd0, 1'b0, fr} * {17'd0, fz_c});
  assign weights[2] = weight_t'({17'd0, fr_c} * {17'd0, 1'b0, fz});
  assign weights[3] = weight_t'({17'd0, 1'b0, fr} * {17'd0, 1'b0, fz});

  // each bank holds exactly one of the four corners
  for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
    localparam logic PR = 1'(g % 2);
    localparam logic PZ = 1'(g / 2);
    logic [RW-1:0] col;
    logic [ZW-1:0] row;
    assign col        = (ir[0] == PR) ? ir : ir1;
    assign row        = (iz[0] == PZ) ? iz : iz1;
    assign rd_addr[g] = bank_addr(32'(col), 32'(row));
  end

  assign ctl.query   = query2_r;
  assign ctl.wr_ok   = wr_ok2_r;
  assign ctl.wr_bank = wr_bank2_r;
  assign wr_addr     = wr_addr2_r;
  assign wr_vec      = vec2_r;
  assign in_range    = ok_r && ok_z;
  assign ir_odd      = ir[0];
  assign iz_odd      = iz[0];

endmodule

// File: design/gvbi_blend.sv
`timescale 1ns / 1ps

module gvbi_blend import gvbi_pkg::*; (
  input  logic                    clk,
  input  stage_en_t               en,
  input  vec_t [NUM_BANKS-1:0]    bank_data,
  input  weight_t [NUM_BANKS-1:0] weights,
  input  logic                    in_range,
  input  logic                    ir_odd,
  input  logic                    iz_odd,
  output vec_t                    out_vec,
  output logic                    out_in_range
);

  // signed component times unsigned weight, kept modulo 2^64
  function automatic logic [63:0] wmul(input logic [31:0] v, input weight_t w);
    return $signed({{32{v[31]}}, v}) * $signed({31'd0, w});
  endfunction

  // stage 3: weights alongside the registered bank reads
  weight_t [NUM_BANKS-1:0] w3_r;
  logic                    ok3_r;
  logic [1:0]              par3_r;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      w3_r   <= weights;
      ok3_r  <= in_range;
      par3_r <= {iz_odd, ir_odd};
    end
  end

  // stage 4: twelve products
  logic [63:0] prod_nxt [3][NUM_BANKS];
  logic [63:0] prod_r   [3][NUM_BANKS];
  logic        ok4_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < NUM_BANKS; k++) begin
        // corner k sits in bank k xor the cell parities
        prod_nxt[c][k] = wmul(bank_data[2'(k) ^ par3_r][COMP_W*c +: COMP_W], w3_r[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      prod_r <= prod_nxt;
      ok4_r  <= ok3_r;
    end
  end

  // stage 5: pair sums, half lsb folded in for rounding
  logic [63:0] sa_r [3];
  logic [63:0] sb_r [3];
  logic        ok5_r;

  always_ff @(posedge clk) begin
    if (en.s5) begin
      for (int c = 0; c < 3; c++) begin
        sa_r[c] <= prod_r[c][0] + prod_r[c][1] + 64'h0000_0000_8000_0000;
        sb_r[c] <= prod_r[c][2] + prod_r[c][3];
      end
      ok5_r <= ok4_r;
    end
  end

  // stage 6: output register
  logic [63:0] tot [3];
  vec_t        out_vec_r;
  logic        out_ok_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      tot[c] = sa_r[c] + sb_r[c];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s6) begin
      out_vec_r.r   <= ok5_r ? tot[0][63:32] : '0;
      out_vec_r.z   <= ok5_r ? tot[1][63:32] : '0;
      out_vec_r.phi <= ok5_r ? tot[2][63:32] : '0;
      out_ok_r      <= ok5_r;
    end
  end

  assign out_vec      = out_vec_r;
  assign out_in_range = out_ok_r;

endmodule

// File: design/grid_vector_bilinear_interp.sv
// six pipeline registers; one transaction per cycle unless out_tready stalls, writes
//   and queries mixed; a query reads its four corners from four parity banks in the
//   same cycle, and a write updates one bank
// write transactions give no result and leave the pipeline after the bank write
// reset: synchronous, active low; clears the pipeline and loads the register defaults;
//   grid memory is not cleared and reads as unknown until written
`timescale 1ns / 1ps

module grid_vector_bilinear_interp import gvbi_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // write_r_index, write_z_index, write_comp_r, write_comp_z, write_comp_phi,
  // point_r, point_z, zero pad
  input  logic [175:0] in_tdata,
  // req_type
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_r, out_z, out_phi
  output logic [95:0]  out_tdata,
  // in_range
  output logic [0:0]   out_tuser,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);

  // configuration registers
  q16_t        r_origin_r;
  q16_t        z_origin_r;
  logic [31:0] r_recip_r;
  logic [31:0] z_recip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_origin_r <= '0;
      z_origin_r <= '0;
      r_recip_r  <= 32'h0001_0000;
      z_recip_r  <= 32'h0001_0000;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_R_ORIGIN: r_origin_r <= cfg_wdata;
        CFG_Z_ORIGIN: z_origin_r <= cfg_wdata;
        CFG_R_RECIP:  r_recip_r  <= cfg_wdata;
        CFG_Z_RECIP:  z_recip_r  <= cfg_wdata;
      endcase
    end
  end

  // pipeline occupancy and per-stage advance
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  stage_en_t en;
  loc_ctl_t  ctl;

  assign en.s6 = !v6_r || out_tready;
  assign en.s5 = !v5_r || en.s6;
  assign en.s4 = !v4_r || en.s5;
  assign en.s3 = !v3_r || en.s4;
  assign en.s2 = !v2_r || en.s3;
  assign en.s1 = !v1_r || en.s2;

  assign in_tready = en.s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en.s1) v1_r <= in_tvalid;
      if (en.s2) v2_r <= v1_r;
      // only queries continue past the bank access
      if (en.s3) v3_r <= v2_r && ctl.query;
      if (en.s4) v4_r <= v3_r;
      if (en.s5) v5_r <= v4_r;
      if (en.s6) v6_r <= v5_r;
    end
  end

  // address and weight generation
  baddr_t                  wr_addr;
  vec_t                    wr_vec;
  baddr_t [NUM_BANKS-1:0]  rd_addr;
  weight_t [NUM_BANKS-1:0] weights;
  logic                    in_range;
  logic                    ir_odd;
  logic                    iz_odd;
  vec_t                    in_vec;

  assign in_vec.r   = in_tdata[43:12];
  assign in_vec.z   = in_tdata[75:44];
  assign in_vec.phi = in_tdata[107:76];

  gvbi_locate u_locate (
    .clk           (clk),
    .en            (en),
    .in_query      (in_tuser[0] == REQ_QUERY),
    .in_wr_r_index (in_tdata[5:0]),
    .in_wr_z_index (in_tdata[11:6]),
    .in_wr_vec     (in_vec),
    .in_point_r    (in_tdata[139:108]),
    .in_point_z    (in_tdata[171:140]),
    .r_origin      (r_origin_r),
    .z_origin      (z_origin_r),
    .r_step_recip  (r_recip_r),
    .z_step_recip  (z_recip_r),
    .ctl           (ctl),
    .wr_addr       (wr_addr),
    .wr_vec        (wr_vec),
    .rd_addr       (rd_addr),
    .weights       (weights),
    .in_range      (in_range),
    .ir_odd        (ir_odd),
    .iz_odd        (iz_odd)
  );

  // parity banks; writes and reads both happen as the transaction leaves stage 2
  vec_t [NUM_BANKS-1:0] bank_data;

  for (genvar g = 0; g < NUM_BANKS; g++) begin : g_ram
    logic we;
    assign we = en.s3 && v2_r && !ctl.query && ctl.wr_ok && (ctl.wr_bank == 2'(g));

    gvbi_bank_ram u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (wr_addr),
      .wdata (wr_vec),
      .re    (en.s3),
      .raddr (rd_addr[g]),
      .rdata (bank_data[g])
    );
  end

  // corner blend and output register
  vec_t out_vec;
  logic out_ok;

  gvbi_blend u_blend (
    .clk          (clk),
    .en           (en),
    .bank_data    (bank_data),
    .weights      (weights),
    .in_range     (in_range),
    .ir_odd       (ir_odd),
    .iz_odd       (iz_odd),
    .out_vec      (out_vec),
    .out_in_range (out_ok)
  );

  assign out_tvalid = v6_r;
  assign out_tdata  = out_vec;
  assign out_tuser  = out_ok;

endmodule
